[src/pcl_pkg.sv]
// Shared types, codes and constants for the positional character list.
// No dependencies; every other file of the block but pcl_ram imports this package.
package pcl_pkg;

    localparam int CAPACITY_DEF = 64;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_DELETE = 2'd1,
        OP_GET    = 2'd2,
        OP_PRINT  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2,
        ST_EMPTY   = 2'd3
    } t_status;

    typedef struct packed {
        t_op        operation;
        logic [7:0] position;
        logic [7:0] item;
    } t_request;

    typedef struct packed {
        t_status    status;
        logic [7:0] character;
        logic       last;
    } t_result;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture request, decode, update count
        logic shift;  // read one entry and queue its move
        logic drain;  // retire the last queued move
        logic put;    // write the new character at its slot
        logic rd;     // read the entry for get or print
        logic ld;     // load the read character into the result
        logic next;   // advance to the next print entry
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_op  op;
        logic ok;
        logic need_shift;
        logic at_end;
        logic last;
    } t_sts;

endpackage

[src/pcl_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pcl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[src/pcl_dp.sv]
// Datapath: request decode, element count, shift pipeline and result register.
// Depends on pcl_pkg and pcl_ram.
module pcl_dp
    import pcl_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_request i_req,
    input  t_cmd     i_cmd,
    output t_sts     o_sts,
    output t_result  o_rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_idx, r_end, r_slot, r_waddr;
    logic          r_wpend;
    logic [7:0]    r_item;
    t_op           r_op;
    logic          r_ok, r_need;
    t_result       r_out;

    logic [8:0]    pos9, n9, pos_add;
    t_status       d_status;
    logic [8:0]    d_slot, d_idx, d_end;
    logic          d_need;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic [7:0]    rd_data;

    always_comb begin
        pos9     = {1'b0, i_req.position};
        n9       = 9'(r_count);
        pos_add  = (pos9 == 9'd0) ? 9'd1 : pos9;
        d_status = ST_OK;
        d_slot   = 9'd0;
        d_idx    = 9'd0;
        d_end    = 9'd0;
        d_need   = 1'b0;
        case (i_req.operation)
            OP_ADD: begin
                if (pos_add > n9 + 9'd1) begin
                    d_status = ST_INVALID;
                end else if (n9 >= 9'(CAPACITY)) begin
                    d_status = ST_FULL;
                end
                d_slot = pos_add - 9'd1;
                d_need = d_slot < n9;
                d_idx  = n9 - 9'd1;
                d_end  = d_slot;
            end
            OP_DELETE: begin
                if (pos9 == 9'd0 || pos9 > n9) begin
                    d_status = ST_INVALID;
                end
                d_slot = pos9 - 9'd1;
                d_need = pos9 < n9;
                d_idx  = pos9;
                d_end  = n9 - 9'd1;
            end
            OP_GET: begin
                if (pos9 == 9'd0 || pos9 > n9) begin
                    d_status = ST_INVALID;
                end
                d_idx = pos9 - 9'd1;
            end
            OP_PRINT: begin
                if (n9 == 9'd0) begin
                    d_status = ST_EMPTY;
                end
            end
            default: begin
                d_status = ST_INVALID;
            end
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.load && d_status == ST_OK) begin
            if (i_req.operation == OP_ADD) begin
                n_count = r_count + CW'(1);
            end else if (i_req.operation == OP_DELETE) begin
                n_count = r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_wpend <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.load || i_cmd.drain) begin
                r_wpend <= 1'b0;
            end else if (i_cmd.shift) begin
                r_wpend <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op            <= i_req.operation;
            r_item          <= i_req.item;
            r_ok            <= (d_status == ST_OK);
            r_need          <= d_need;
            r_slot          <= d_slot[AW-1:0];
            r_idx           <= d_idx[AW-1:0];
            r_end           <= d_end[AW-1:0];
            r_out.status    <= d_status;
            r_out.character <= 8'd0;
            r_out.last      <= 1'b1;
        end
        if (i_cmd.shift) begin
            // Queue the move of the entry read now; walk toward the end index.
            if (r_op == OP_ADD) begin
                r_waddr <= r_idx + AW'(1);
                r_idx   <= r_idx - AW'(1);
            end else begin
                r_waddr <= r_idx - AW'(1);
                r_idx   <= r_idx + AW'(1);
            end
        end
        if (i_cmd.ld) begin
            r_out.status    <= ST_OK;
            r_out.character <= rd_data;
            r_out.last      <= (r_op != OP_PRINT) || (r_idx == AW'(r_count - CW'(1)));
        end
        if (i_cmd.next) begin
            r_idx <= r_idx + AW'(1);
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_waddr;
        wr_data = rd_data;
        if (i_cmd.put) begin
            wr_en   = 1'b1;
            wr_addr = r_slot;
            wr_data = r_item;
        end else if (r_wpend) begin
            wr_en = 1'b1;
        end
    end

    pcl_ram #(
        .WIDTH (8),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (i_cmd.shift || i_cmd.rd),
        .i_rd_addr (r_idx),
        .o_rd_data (rd_data)
    );

    assign o_sts.op         = r_op;
    assign o_sts.ok         = r_ok;
    assign o_sts.need_shift = r_need;
    assign o_sts.at_end     = (r_idx == r_end);
    assign o_sts.last       = r_out.last;
    assign o_rsp            = r_out;

endmodule

[src/pcl_ctrl.sv]
// Controller: sequences decode, entry shifting, reads and result handshakes.
// Depends on pcl_pkg.
module pcl_ctrl
    import pcl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_DISP  = 8'b0000_0010,
        S_SHIFT = 8'b0000_0100,
        S_DRAIN = 8'b0000_1000,
        S_PUT   = 8'b0001_0000,
        S_RD    = 8'b0010_0000,
        S_LD    = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                if (!i_sts.ok) begin
                    n_state = S_OUT;
                end else begin
                    case (i_sts.op)
                        OP_ADD:    n_state = i_sts.need_shift ? S_SHIFT : S_PUT;
                        OP_DELETE: n_state = i_sts.need_shift ? S_SHIFT : S_OUT;
                        default:   n_state = S_RD;
                    endcase
                end
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
                if (i_sts.at_end) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                o_cmd.drain = 1'b1;
                n_state     = (i_sts.op == OP_ADD) ? S_PUT : S_OUT;
            end
            S_PUT: begin
                o_cmd.put = 1'b1;
                n_state   = S_OUT;
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_LD;
            end
            S_LD: begin
                o_cmd.ld = 1'b1;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (i_rsp_ready) begin
                    if (i_sts.op == OP_PRINT && !i_sts.last) begin
                        o_cmd.next = 1'b1;
                        n_state    = S_RD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = (r_state == S_OUT);

endmodule

[src/positional_char_list_core.sv]
// Top level of the positional character list: controller, datapath and store.
// Depends on pcl_pkg, pcl_ctrl and pcl_dp (which holds pcl_ram).
//
//   channel   valid         ready         payload
//   request   i_req_valid   o_req_ready   i_req  (t_request)
//   result    o_rsp_valid   i_rsp_ready   o_rsp  (t_result)
//
// One request at a time. A get decodes, reads its entry and loads the result;
// an add that moves entries shifts them, retires the last move and then writes
// the new character, and such a delete shifts and retires only, one entry per cycle
// through the single read port and write port of the store. Print reads and
// loads each character, then waits for each result to be taken. Reset clears
// the count and the controller; the store keeps its contents and needs no clearing.
// A stalled result holds in its register until taken.
module positional_char_list_core
    import pcl_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_req_valid,
    output logic     o_req_ready,
    input  t_request i_req,
    output logic     o_rsp_valid,
    input  logic     i_rsp_ready,
    output t_result  o_rsp
);

    t_cmd cmd;
    t_sts sts;

    pcl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    pcl_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_rsp   (o_rsp)
    );

    // A request is never taken while a result is on offer.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_req_ready && o_rsp_valid))
        else $error("request ready while result valid");

    // A result never follows its request in the next cycle.
    a_decode_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready) |=> !o_rsp_valid)
        else $error("result too soon after request");

    // After the final result is taken the block is ready for the next request.
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && i_rsp_ready && o_rsp.last) |=> o_req_ready)
        else $error("block not ready after final result");

    // A print result that is not final leads to more output, not a new request.
    a_print_more: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && i_rsp_ready && !o_rsp.last) |=> (!o_req_ready && !o_rsp_valid))
        else $error("print stopped before final result");

endmodule

[tb/positional_char_list_core_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for positional_char_list_core: directed table, then random traffic.
// Depends on pcl_pkg and the core; carries its own list model to predict results not fixed by the table.
module positional_char_list_core_test;
    import pcl_pkg::*;

    localparam int CAP         = CAPACITY_DEF;
    localparam int STALL_LIMIT = 1000;
    localparam int TAIL_CYCLES = 80;
    localparam int RAND_ITEMS  = 380;
    localparam int CALM_ITEMS  = 60;
    localparam int MODE_ADDS   = 0;
    localparam int MODE_MIXED  = 1;
    localparam int MODE_DROPS  = 2;

    typedef struct packed {
        t_request req;
        logic     typed;
        t_result  want;
    } t_row;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_req_valid;
    logic     o_req_ready;
    t_request i_req;
    logic     o_rsp_valid;
    logic     i_rsp_ready = 1'b1;
    t_result  o_rsp;

    // list model
    logic [7:0] char_store [CAP];
    int         char_count;
    t_result    step_rsp [CAP];
    t_result    awaited_rsp [$];

    t_row       directed_rows [$];
    logic       row_typed;
    t_result    row_expect;

    int  errors;
    int  idle_cycles;
    int  rsp_checked;
    int  full_hits;
    int  peak_count;
    int  op_seen [4];
    bit  calm;
    bit  rx_stall;
    int  rx_left;
    int  n_new;
    int  k;
    t_result got;
    t_result want;

    positional_char_list_core #(
        .CAPACITY(CAP)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_req_valid(i_req_valid),
        .o_req_ready(o_req_ready),
        .i_req(i_req),
        .o_rsp_valid(o_rsp_valid),
        .i_rsp_ready(i_rsp_ready),
        .o_rsp(o_rsp)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_result mk_rsp(input t_status s, input logic [7:0] c, input logic l);
        t_result r;
        r.status    = s;
        r.character = c;
        r.last      = l;
        return r;
    endfunction

    // Apply one request to the list model; fill step_rsp and return the result count.
    function automatic int list_update(input t_request r);
        int pos;
        int i;
        pos = int'(r.position);
        case (r.operation)
            OP_ADD: begin
                if (pos == 0) pos = 1;
                if (pos > char_count + 1) begin
                    step_rsp[0] = mk_rsp(ST_INVALID, 8'h00, 1'b1);
                end else if (char_count >= CAP) begin
                    step_rsp[0] = mk_rsp(ST_FULL, 8'h00, 1'b1);
                end else begin
                    for (i = char_count; i > pos - 1; i--) char_store[i] = char_store[i - 1];
                    char_store[pos - 1] = r.item;
                    char_count++;
                    step_rsp[0] = mk_rsp(ST_OK, 8'h00, 1'b1);
                end
                return 1;
            end
            OP_DELETE: begin
                if (pos == 0 || pos > char_count) begin
                    step_rsp[0] = mk_rsp(ST_INVALID, 8'h00, 1'b1);
                end else begin
                    for (i = pos - 1; i + 1 < char_count; i++) char_store[i] = char_store[i + 1];
                    char_count--;
                    step_rsp[0] = mk_rsp(ST_OK, 8'h00, 1'b1);
                end
                return 1;
            end
            OP_GET: begin
                if (pos == 0 || pos > char_count)
                    step_rsp[0] = mk_rsp(ST_INVALID, 8'h00, 1'b1);
                else
                    step_rsp[0] = mk_rsp(ST_OK, char_store[pos - 1], 1'b1);
                return 1;
            end
            default: begin
                if (char_count == 0) begin
                    step_rsp[0] = mk_rsp(ST_EMPTY, 8'h00, 1'b1);
                    return 1;
                end
                for (i = 0; i < char_count; i++)
                    step_rsp[i] = mk_rsp(ST_OK, char_store[i], i + 1 == char_count);
                return char_count;
            end
        endcase
    endfunction

    function automatic t_request pick_request(input int mode);
        t_request r;
        int       w;
        w = $urandom_range(0, 99);
        case (mode)
            MODE_ADDS:  r.operation = w < 60 ? OP_ADD : w < 75 ? OP_DELETE :
                                      w < 92 ? OP_GET : OP_PRINT;
            MODE_MIXED: r.operation = w < 35 ? OP_ADD : w < 65 ? OP_DELETE :
                                      w < 88 ? OP_GET : OP_PRINT;
            default:    r.operation = w < 15 ? OP_ADD : w < 75 ? OP_DELETE :
                                      w < 90 ? OP_GET : OP_PRINT;
        endcase
        // mostly positions near the live range, now and then anything
        if ($urandom_range(0, 9) == 0)
            r.position = 8'($urandom_range(0, 255));
        else
            r.position = 8'($urandom_range(0, char_count + 1));
        r.item = 8'($urandom_range(0, 255));
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input t_result w, input t_result g);
        errors++;
        if (errors <= 10)
            $display("%0t: %s: expected status %0d char %02h last %0d, %s %0d char %02h last %0d",
                     $realtime, what, w.status, w.character, w.last, "got status",
                     g.status, g.character, g.last);
    endtask

    task automatic add_row(input t_op op, input int pos, input int item, input bit typed,
                           input t_status st);
        t_row r;
        r.req.operation = op;
        r.req.position  = 8'(pos);
        r.req.item      = 8'(item);
        r.typed         = typed;
        r.want          = mk_rsp(st, 8'h00, 1'b1);
        directed_rows.push_back(r);
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input t_request r, input bit typed, input t_result w);
        row_typed  = typed;
        row_expect = w;
        i_req_valid <= 1'b1;
        i_req       <= r;
        @(posedge i_clk);
        while (!o_req_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic idle_sender(input int n);
        i_req_valid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic maybe_gap;
        if (!calm && $urandom_range(0, 3) == 0) idle_sender($urandom_range(1, 16));
    endtask

    task automatic send_random(input t_request r);
        send_request(r, 1'b0, '0);
        maybe_gap();
    endtask

    // Result side: stall in bursts, otherwise take results for a stretch.
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_stall = !calm && !rx_stall && ($urandom_range(0, 2) == 0);
            rx_left  = rx_stall ? $urandom_range(1, 16) : $urandom_range(1, 30);
        end
        rx_left = rx_left - 1;
        i_rsp_ready <= calm || !rx_stall;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_req_valid && o_req_ready) begin
                n_new = list_update(i_req);
                op_seen[i_req.operation]++;
                if (char_count > peak_count) peak_count = char_count;
                if (row_typed)
                    awaited_rsp.push_back(row_expect);
                else
                    for (k = 0; k < n_new; k++) awaited_rsp.push_back(step_rsp[k]);
            end
            if (o_rsp_valid && i_rsp_ready) begin
                got = o_rsp;
                rsp_checked++;
                if (got.status == ST_FULL) full_hits++;
                if (awaited_rsp.size() == 0) begin
                    flag_mismatch("unexpected result", '0, got);
                end else begin
                    want = awaited_rsp.pop_front();
                    if (got.status !== want.status || got.character !== want.character
                        || got.last !== want.last)
                        flag_mismatch("result mismatch", want, got);
                end
            end
            if ((i_req_valid && o_req_ready) || (o_rsp_valid && i_rsp_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    initial begin
        while (idle_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("Timeout: no request or result moved for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        t_request r;
        int       mode;
        errors      = 0;
        idle_cycles = 0;
        rsp_checked = 0;
        full_hits   = 0;
        peak_count  = 0;
        char_count  = 0;
        calm        = 1'b0;
        rx_stall    = 1'b0;
        rx_left     = 0;
        row_typed   = 1'b0;
        row_expect  = '0;
        for (k = 0; k < 4; k++) op_seen[k] = 0;
        i_rst_n     <= 1'b0;
        i_req_valid <= 1'b0;
        i_req       <= '0;

        // empty list, then a few entries at the front, the end and out of range
        add_row(OP_GET,    0,   0,   1, ST_INVALID);
        add_row(OP_PRINT,  0,   0,   1, ST_EMPTY);
        add_row(OP_DELETE, 1,   0,   1, ST_INVALID);
        add_row(OP_ADD,    2,   8'h11, 1, ST_INVALID);
        add_row(OP_ADD,    0,   8'hFF, 1, ST_OK);
        add_row(OP_ADD,    1,   8'h00, 1, ST_OK);
        add_row(OP_ADD,    3,   8'hA5, 1, ST_OK);
        add_row(OP_ADD,    255, 8'h5A, 1, ST_INVALID);
        add_row(OP_GET,    1,   0,   0, ST_OK);
        add_row(OP_GET,    3,   0,   0, ST_OK);
        add_row(OP_GET,    255, 0,   1, ST_INVALID);
        add_row(OP_PRINT,  0,   0,   0, ST_OK);
        add_row(OP_DELETE, 0,   0,   1, ST_INVALID);
        add_row(OP_DELETE, 4,   0,   1, ST_INVALID);
        add_row(OP_DELETE, 2,   0,   1, ST_OK);
        add_row(OP_DELETE, 2,   0,   1, ST_OK);
        add_row(OP_GET,    1,   0,   0, ST_OK);
        add_row(OP_ADD,    2,   8'h80, 1, ST_OK);
        add_row(OP_ADD,    1,   8'h7F, 1, ST_OK);
        add_row(OP_PRINT,  0,   0,   0, ST_OK);

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i]) begin
            send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
            maybe_gap();
        end

        // hold the requests until every result is back
        i_req_valid <= 1'b0;
        while (awaited_rsp.size() != 0) @(negedge i_clk);

        // fill to capacity, then poke the full list
        while (char_count < CAP) begin
            r.operation = OP_ADD;
            r.position  = 8'($urandom_range(0, char_count + 1));
            r.item      = 8'($urandom_range(0, 255));
            send_random(r);
        end
        r.item = 8'($urandom_range(0, 255));
        r.operation = OP_ADD;    r.position = 8'(CAP + 1); send_random(r);
        r.operation = OP_ADD;    r.position = 8'd0;        send_random(r);
        r.operation = OP_ADD;    r.position = 8'(CAP + 2); send_random(r);
        r.operation = OP_GET;    r.position = 8'(CAP);     send_random(r);
        r.operation = OP_PRINT;  r.position = 8'd0;        send_random(r);
        r.operation = OP_DELETE; r.position = 8'(CAP);     send_random(r);
        r.operation = OP_DELETE; r.position = 8'd1;        send_random(r);

        for (int n = 0; n < RAND_ITEMS; n++) begin
            mode = (n / 64) % 3 == 0 ? MODE_DROPS : (n / 64) % 3 == 1 ? MODE_ADDS : MODE_MIXED;
            if (n == RAND_ITEMS - CALM_ITEMS) calm = 1'b1;
            send_random(pick_request(mode));
        end

        i_req_valid <= 1'b0;
        while (awaited_rsp.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Requests: %0d add, %0d delete, %0d get, %0d print; %0d results checked",
                 op_seen[OP_ADD], op_seen[OP_DELETE], op_seen[OP_GET], op_seen[OP_PRINT],
                 rsp_checked);
        $display("List reached %0d of %0d entries, %0d adds refused as full, %0d mismatches",
                 peak_count, CAP, full_hits, errors);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
